// ----- hdl/msq_pkg.sv -----
// Package for the message slot queue core: request and response payload types,
// slot entry layout, operation, status and slot state codes, and controller states.
// No dependencies.
`timescale 1ns / 1ps

package msq_pkg;

	// Operation codes of a request.
	localparam logic [2:0] OP_SEND = 3'd0;
	localparam logic [2:0] OP_GET  = 3'd1;
	localparam logic [2:0] OP_PUT  = 3'd2;
	localparam logic [2:0] OP_READ = 3'd3;
	localparam logic [2:0] OP_RET  = 3'd4;

	// Status codes of a response.
	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_NO_FREE = 3'd1;
	localparam logic [2:0] STS_TOO_BIG = 3'd2;
	localparam logic [2:0] STS_NO_MSG  = 3'd3;
	localparam logic [2:0] STS_INVALID = 3'd4;

	// Slot life cycle codes.
	localparam logic [1:0] SS_FREE   = 2'd0;
	localparam logic [1:0] SS_FILLED = 2'd1;
	localparam logic [1:0] SS_READ   = 2'd2;

	// Register addresses (word index on the configuration port).
	localparam logic REG_SLOTS = 1'b0;
	localparam logic REG_BYTES = 1'b1;

	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 32;
	localparam int SLOTS_W = 5;

	typedef logic [3:0] sid_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  msg_id;
		logic [15:0] message_length;
		logic [15:0] byte_offset;
		logic [15:0] read_capacity;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		sid_t        slot_id;
		logic [15:0] byte_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] len;
	} slot_ent_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FIN
	} ctl_state_t;

endpackage

// ----- hdl/msq_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module msq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/message_slot_queue_core.sv -----
// Top level of the message slot queue core: slot pool with a free stack and a
// filled FIFO, kept in three synchronous RAMs. Depends on msq_pkg and msq_ram.
`timescale 1ns / 1ps

//  Channel    Direction  Handshake                Payload
//  req        in         req_valid / req_ready    msq_pkg::req_t
//  rsp        out        rsp_valid / rsp_ready    msq_pkg::rsp_t
//  APB cfg    in         psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// A request is taken in the idle state and issues reads of the slot table, the
// top of the free stack and the head of the filled FIFO. In the lookup state the
// data is back and the request commits. A get that finds a message waiting
// reads the slot table a second time, at the slot named by the FIFO head, and
// commits in the final state; a get on an empty FIFO commits in the lookup state.
// The response sits in an output register; a new request is accepted while it
// waits, and only the commit step stalls when the register is still occupied.
// Reset and every write of the slot count reinitialize the pool at once: valid
// bits on the slot table and the free stack make unwritten entries read as free
// and as their initial stack contents, so there is no clearing pass.

module message_slot_queue_core #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request channel.
	input  logic                          req_valid,
	output logic                          req_ready,
	input  msq_pkg::req_t                 req_data,
	// Response channel.
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output msq_pkg::rsp_t                 rsp_data,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msq_pkg::CFG_AW-1:0]    paddr,
	input  logic [msq_pkg::CFG_DW-1:0]    pwdata,
	output logic [msq_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready
);

	// Slot id width and the width of counters that must reach MAX_SLOTS.
	localparam int IDW         = $clog2(MAX_SLOTS);
	localparam int CW          = $clog2(MAX_SLOTS + 1);
	localparam int RST_SLOTS_I = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;
	localparam int ENT_W       = $bits(msq_pkg::slot_ent_t);

	// Configuration registers. The slot count is stored after saturation.
	logic [msq_pkg::SLOTS_W-1:0] slots_q;
	logic [15:0]                 bytes_q;
	logic [msq_pkg::SLOTS_W-1:0] wr_slots;
	logic                        cfg_wr;

	// Pool bookkeeping.
	logic [CW-1:0]        free_cnt_q, free_cnt_d;
	logic [CW-1:0]        fill_cnt_q, fill_cnt_d;
	logic [IDW-1:0]       head_q, head_d;
	logic [MAX_SLOTS-1:0] slot_vld_q;
	logic [MAX_SLOTS-1:0] stk_vld_q;

	// Controller.
	msq_pkg::ctl_state_t state_q, state_d;
	msq_pkg::req_t       req_q;
	msq_pkg::rsp_t       rsp_q, res;
	logic                rsp_valid_q;
	logic                out_free;
	logic                finish;

	// Memory ports.
	logic                slot_we, slot_re;
	logic [IDW-1:0]      slot_waddr, slot_raddr, slot_raddr_q;
	msq_pkg::slot_ent_t  slot_wdata;
	logic [ENT_W-1:0]    slot_rdata;
	logic                stk_we, stk_re;
	logic [IDW-1:0]      stk_waddr, stk_raddr, stk_raddr_q, stk_wdata, stk_rdata;
	logic                ring_we, ring_re;
	logic [IDW-1:0]      ring_waddr, ring_raddr, ring_wdata, ring_rdata;

	// Values seen through the valid bits.
	msq_pkg::slot_ent_t  slot_ent;
	logic [1:0]          slot_st;
	logic [IDW-1:0]      stk_top;
	logic [IDW-1:0]      req_idx;
	logic                id_ok;
	logic [CW:0]         tail_sum;
	logic [IDW-1:0]      tail_idx, head_dec, head_inc;
	logic [15:0]         left;

	msq_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	msq_ram #(.WIDTH(IDW), .DEPTH(MAX_SLOTS)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	msq_ram #(.WIDTH(IDW), .DEPTH(MAX_SLOTS)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Configuration port. Writes complete in the access phase; reads are
	// served from the registers with no wait states.
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign wr_slots = (32'(pwdata[msq_pkg::SLOTS_W-1:0]) > MAX_SLOTS) ?
		msq_pkg::SLOTS_W'(MAX_SLOTS) : pwdata[msq_pkg::SLOTS_W-1:0];

	always_comb begin
		if (paddr[2] == msq_pkg::REG_BYTES) begin
			prdata = {16'd0, bytes_q};
		end else begin
			prdata = {{(msq_pkg::CFG_DW - msq_pkg::SLOTS_W){1'b0}}, slots_q};
		end
	end

	// A slot entry that was never written since the last reinit is free. A
	// stack entry that was never written holds its initial id, which puts
	// slot zero on top: entry i holds slots_in_use - 1 - i.
	assign slot_ent = msq_pkg::slot_ent_t'(slot_rdata);
	assign slot_st  = slot_vld_q[slot_raddr_q] ? slot_ent.st : msq_pkg::SS_FREE;
	assign stk_top  = stk_vld_q[stk_raddr_q] ? stk_rdata :
		IDW'(32'(slots_q) - 32'd1 - 32'(stk_raddr_q));

	assign req_idx  = IDW'(req_q.msg_id);
	assign id_ok    = req_q.msg_id < {3'b000, slots_q};

	// The filled FIFO wraps at MAX_SLOTS. The tail only matters on a send,
	// where the filled count is below the slot count, so one compare and
	// subtract keeps it in range.
	assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(fill_cnt_q);
	assign tail_idx = (tail_sum >= (CW + 1)'(MAX_SLOTS)) ?
		IDW'(tail_sum - (CW + 1)'(MAX_SLOTS)) : IDW'(tail_sum);
	assign head_dec = (head_q == '0) ? IDW'(MAX_SLOTS - 1) : head_q - 1'b1;
	assign head_inc = (head_q == IDW'(MAX_SLOTS - 1)) ? '0 : head_q + 1'b1;

	assign left     = slot_ent.len - req_q.byte_offset;
	assign out_free = !rsp_valid_q || rsp_ready;

	// Controller: issue reads on accept, then commit the read-modify-write.
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		finish     = 1'b0;
		res        = '0;
		free_cnt_d = free_cnt_q;
		fill_cnt_d = fill_cnt_q;
		head_d     = head_q;
		slot_re    = 1'b0;
		slot_raddr = req_idx;
		slot_we    = 1'b0;
		slot_waddr = req_idx;
		slot_wdata = '0;
		stk_re     = 1'b0;
		stk_raddr  = IDW'(free_cnt_q - 1'b1);
		stk_we     = 1'b0;
		stk_waddr  = IDW'(free_cnt_q);
		stk_wdata  = req_idx;
		ring_re    = 1'b0;
		ring_raddr = head_q;
		ring_we    = 1'b0;
		ring_waddr = tail_idx;
		ring_wdata = stk_top;

		case (state_q)
			msq_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					slot_re    = 1'b1;
					slot_raddr = IDW'(req_data.msg_id);
					stk_re     = 1'b1;
					ring_re    = 1'b1;
					state_d    = msq_pkg::ST_LOOK;
				end
			end

			msq_pkg::ST_LOOK: begin
				if (req_q.operation == msq_pkg::OP_GET && fill_cnt_q != '0) begin
					// Second lookup: the slot named by the FIFO head.
					slot_re    = 1'b1;
					slot_raddr = ring_rdata;
					state_d    = msq_pkg::ST_FIN;
				end else if (out_free) begin
					finish  = 1'b1;
					state_d = msq_pkg::ST_IDLE;
					case (req_q.operation)
						msq_pkg::OP_SEND: begin
							if (free_cnt_q == '0) begin
								res.status = msq_pkg::STS_NO_FREE;
							end else if (req_q.message_length > bytes_q) begin
								res.status = msq_pkg::STS_TOO_BIG;
							end else begin
								slot_we        = 1'b1;
								slot_waddr     = stk_top;
								slot_wdata.st  = msq_pkg::SS_FILLED;
								slot_wdata.len = req_q.message_length;
								ring_we        = 1'b1;
								ring_waddr     = tail_idx;
								ring_wdata     = stk_top;
								free_cnt_d     = free_cnt_q - 1'b1;
								fill_cnt_d     = fill_cnt_q + 1'b1;
								res.slot_id    = msq_pkg::sid_t'(stk_top);
								res.byte_count = req_q.message_length;
							end
						end
						msq_pkg::OP_GET: begin
							// Only reached with an empty FIFO.
							res.status = msq_pkg::STS_NO_MSG;
						end
						msq_pkg::OP_PUT: begin
							if (!id_ok || slot_st != msq_pkg::SS_READ) begin
								res.status = msq_pkg::STS_INVALID;
							end else begin
								slot_we        = 1'b1;
								slot_wdata.st  = msq_pkg::SS_FREE;
								slot_wdata.len = slot_ent.len;
								stk_we         = 1'b1;
								free_cnt_d     = free_cnt_q + 1'b1;
							end
						end
						msq_pkg::OP_READ: begin
							if (!id_ok) begin
								res.status = msq_pkg::STS_INVALID;
							end else if (slot_st != msq_pkg::SS_READ) begin
								res.status = msq_pkg::STS_NO_MSG;
							end else if (req_q.byte_offset >= slot_ent.len) begin
								res.status = msq_pkg::STS_INVALID;
							end else begin
								res.byte_count = (req_q.read_capacity < left) ?
									req_q.read_capacity : left;
							end
						end
						msq_pkg::OP_RET: begin
							if (!id_ok) begin
								res.status = msq_pkg::STS_INVALID;
							end else if (slot_st != msq_pkg::SS_READ) begin
								res.status = msq_pkg::STS_NO_MSG;
							end else begin
								slot_we        = 1'b1;
								slot_wdata.st  = msq_pkg::SS_FILLED;
								slot_wdata.len = slot_ent.len;
								ring_we        = 1'b1;
								ring_waddr     = head_dec;
								ring_wdata     = req_idx;
								head_d         = head_dec;
								fill_cnt_d     = fill_cnt_q + 1'b1;
							end
						end
						default: begin
							res.status = msq_pkg::STS_INVALID;
						end
					endcase
				end
			end

			msq_pkg::ST_FIN: begin
				// Get with a message waiting: the slot entry is now on the read port.
				if (out_free) begin
					finish         = 1'b1;
					state_d        = msq_pkg::ST_IDLE;
					slot_we        = 1'b1;
					slot_waddr     = ring_rdata;
					slot_wdata.st  = msq_pkg::SS_READ;
					slot_wdata.len = slot_ent.len;
					head_d         = head_inc;
					fill_cnt_d     = fill_cnt_q - 1'b1;
					res.slot_id    = msq_pkg::sid_t'(ring_rdata);
					res.byte_count = slot_ent.len;
				end
			end

			default: begin
				state_d = msq_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state, counters, valid bits and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msq_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			slots_q     <= msq_pkg::SLOTS_W'(RST_SLOTS_I);
			bytes_q     <= 16'd4096;
			free_cnt_q  <= CW'(RST_SLOTS_I);
			fill_cnt_q  <= '0;
			head_q      <= '0;
			slot_vld_q  <= '0;
			stk_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr && paddr[2] == msq_pkg::REG_SLOTS) begin
				// Reinitialize the pool: everything free, FIFO empty.
				slots_q    <= wr_slots;
				free_cnt_q <= CW'(wr_slots);
				fill_cnt_q <= '0;
				head_q     <= '0;
				slot_vld_q <= '0;
				stk_vld_q  <= '0;
			end else begin
				if (cfg_wr) begin
					bytes_q <= pwdata[15:0];
				end
				free_cnt_q <= free_cnt_d;
				fill_cnt_q <= fill_cnt_d;
				head_q     <= head_d;
				if (slot_we) begin
					slot_vld_q[slot_waddr] <= 1'b1;
				end
				if (stk_we) begin
					stk_vld_q[stk_waddr] <= 1'b1;
				end
			end
		end
	end

	// Request, read addresses and response payload.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req_data;
		end
		if (slot_re) begin
			slot_raddr_q <= slot_raddr;
		end
		if (stk_re) begin
			stk_raddr_q <= stk_raddr;
		end
		if (finish) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// A slot is counted at most once, as free or as filled.
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_cnt_q) + 32'(fill_cnt_q) <= 32'(slots_q))
		else $error("free and filled counts exceed the slot count");

	// A request accepted in idle is always looked up in the next cycle.
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == msq_pkg::ST_LOOK)
		else $error("accepted request did not enter the lookup step");

	// A commit never overwrites a response that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |-> !finish)
		else $error("response register overwritten while stalled");

	// A new response only appears after a commit step.
	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) != msq_pkg::ST_IDLE)
		else $error("response raised without a commit step");

	// The RAMs are never written while a request is being accepted.
	a_no_write_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msq_pkg::ST_IDLE |-> !slot_we && !stk_we && !ring_we)
		else $error("memory written in idle");

endmodule

// ----- bench/message_slot_queue_core_tb.sv -----
// Self-checking testbench for message_slot_queue_core: directed probes, then random
// request streams over several pool settings, checked against an in-bench slot pool model.
// Depends on msq_pkg and the message_slot_queue_core RTL.
`timescale 1ns / 1ps

module message_slot_queue_core_tb;

	localparam int SLOT_MAX    = 16;
	localparam int HOLD_CYCLES = 90;
	localparam int PHASES      = 8;
	localparam int PROBES      = 26;
	localparam logic [15:0] FULL16 = 16'hFFFF;

	// Operation codes the block does not define; each must be refused.
	localparam logic [2:0] OP_BAD5 = 3'd5;
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;

	localparam logic [msq_pkg::CFG_AW-1:0] ADDR_SLOTS = {msq_pkg::REG_SLOTS, 2'b00};
	localparam logic [msq_pkg::CFG_AW-1:0] ADDR_BYTES = {msq_pkg::REG_BYTES, 2'b00};

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	msq_pkg::req_t req_data = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	msq_pkg::rsp_t rsp_data;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [msq_pkg::CFG_AW-1:0] paddr = '0;
	logic [msq_pkg::CFG_DW-1:0] pwdata = '0;
	logic [msq_pkg::CFG_DW-1:0] prdata;
	logic          pready;

	message_slot_queue_core #(.MAX_SLOTS(SLOT_MAX)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the slot pool, advanced once per accepted request.
	int          pool_slots;
	logic [15:0] slot_cap;
	logic [1:0]  slot_st [SLOT_MAX];
	logic [15:0] slot_len [SLOT_MAX];
	int          free_stk [SLOT_MAX];
	int          free_cnt;
	int          fifo_ring [SLOT_MAX];
	int          fifo_head;
	int          fifo_cnt;

	// Answers owed by the block, oldest first.
	msq_pkg::rsp_t pool_answers [$];
	int            err_cnt = 0;

	// calm and hold_go are shared between the two sides; hold_left is the response side's count.
	bit calm = 1'b0;
	bit hold_go = 1'b0;
	int hold_left = 0;

	typedef struct packed {
		msq_pkg::req_t r;
		logic          typed;
		msq_pkg::rsp_t e;
	} probe_t;

	// Directed probes, run at the reset setting of 16 slots of 4096 bytes. Rows with
	// typed set carry their answer; the rest are checked against the shadow pool.
	probe_t probe_tab [PROBES] = '{
		// Empty pool: nothing filled and nothing held for reading.
		'{'{msq_pkg::OP_GET,  8'd0,  16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_NO_MSG,  4'd0, 16'd0}},
		'{'{msq_pkg::OP_PUT,  8'd0,  16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_INVALID, 4'd0, 16'd0}},
		'{'{msq_pkg::OP_READ, 8'd0,  16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_NO_MSG,  4'd0, 16'd0}},
		'{'{msq_pkg::OP_RET,  8'd15, 16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_NO_MSG,  4'd0, 16'd0}},
		// Ids past the slot count, and operation codes with no meaning.
		'{'{msq_pkg::OP_READ, 8'hFF, FULL16,   FULL16,   FULL16}, 1'b1,
			'{msq_pkg::STS_INVALID, 4'd0, 16'd0}},
		'{'{msq_pkg::OP_PUT,  8'd16, 16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_INVALID, 4'd0, 16'd0}},
		'{'{msq_pkg::OP_RET,  8'hAA, 16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_INVALID, 4'd0, 16'd0}},
		'{'{OP_BAD5,          8'hFF, FULL16,   FULL16,   FULL16}, 1'b1,
			'{msq_pkg::STS_INVALID, 4'd0, 16'd0}},
		'{'{OP_BAD7,          8'd0,  16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_INVALID, 4'd0, 16'd0}},
		'{'{OP_BAD6,          8'd3,  16'd1,    16'd1,    16'd1},  1'b1,
			'{msq_pkg::STS_INVALID, 4'd0, 16'd0}},
		// Sends just over the capacity and at the top of the field.
		'{'{msq_pkg::OP_SEND, 8'd0,  16'd4097, 16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_TOO_BIG, 4'd0, 16'd0}},
		'{'{msq_pkg::OP_SEND, 8'hFF, FULL16,   16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_TOO_BIG, 4'd0, 16'd0}},
		// A full-size send and a zero-length send take slots 0 and 1 off the stack.
		'{'{msq_pkg::OP_SEND, 8'd0,  16'd4096, 16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_OK,  4'd0, 16'd4096}},
		'{'{msq_pkg::OP_SEND, 8'd0,  16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_OK,  4'd1, 16'd0}},
		'{'{msq_pkg::OP_GET,  8'd0,  16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_OK,  4'd0, 16'd4096}},
		// Reads at the first byte, the last byte, one past the end, and no capacity.
		'{'{msq_pkg::OP_READ, 8'd0,  16'd0,    16'd0,    FULL16}, 1'b1,
			'{msq_pkg::STS_OK,  4'd0, 16'd4096}},
		'{'{msq_pkg::OP_READ, 8'd0,  16'd0,    16'd4095, FULL16}, 1'b1,
			'{msq_pkg::STS_OK,  4'd0, 16'd1}},
		'{'{msq_pkg::OP_READ, 8'd0,  16'd0,    16'd4096, 16'd5},  1'b1,
			'{msq_pkg::STS_INVALID, 4'd0, 16'd0}},
		'{'{msq_pkg::OP_READ, 8'd0,  16'd0,    16'd16,   16'd0},  1'b1,
			'{msq_pkg::STS_OK,  4'd0, 16'd0}},
		'{'{msq_pkg::OP_RET,  8'd0,  16'd0,    16'd0,    16'd0},  1'b1,
			'{msq_pkg::STS_OK,  4'd0, 16'd0}},
		// Returned slot comes out first; double put; read of an empty message.
		'{'{msq_pkg::OP_GET,  8'd0,  16'd0,    16'd0,    16'd0},  1'b0, '0},
		'{'{msq_pkg::OP_PUT,  8'd0,  16'd0,    16'd0,    16'd0},  1'b0, '0},
		'{'{msq_pkg::OP_PUT,  8'd0,  16'd0,    16'd0,    16'd0},  1'b0, '0},
		'{'{msq_pkg::OP_GET,  8'd0,  16'd0,    16'd0,    16'd0},  1'b0, '0},
		'{'{msq_pkg::OP_READ, 8'd1,  16'd0,    16'd0,    16'd7},  1'b0, '0},
		'{'{msq_pkg::OP_PUT,  8'd1,  16'd0,    16'd0,    16'd0},  1'b0, '0}
	};

	// Pool settings walked by the random part: slot count, slot size, request count.
	int unsigned ph_slots [PHASES] = '{5, 1, 16, 0, 31, 3, 16, 12};
	int unsigned ph_bytes [PHASES] = '{100, 65535, 1, 4096, 2000, 0, 65535, 700};
	int          ph_items [PHASES] = '{220, 220, 220, 40, 220, 220, 220, 220};

	function automatic void pool_reset();
		int i;
		for (i = 0; i < SLOT_MAX; i++) begin
			slot_st[i] = msq_pkg::SS_FREE;
			slot_len[i] = '0;
			free_stk[i] = 0;
			fifo_ring[i] = 0;
		end
		// The top of the stack is the last used entry, so id 0 ends up on top.
		for (i = 0; i < pool_slots; i++)
			free_stk[i] = pool_slots - 1 - i;
		free_cnt = pool_slots;
		fifo_head = 0;
		fifo_cnt = 0;
	endfunction

	function automatic msq_pkg::rsp_t pool_apply(input msq_pkg::req_t r);
		msq_pkg::rsp_t o;
		int   s;
		int   id;
		bit   id_ok;
		int   left;
		o = '0;
		o.status = msq_pkg::STS_OK;
		id = r.msg_id;
		id_ok = (id < pool_slots);
		case (r.operation)
			msq_pkg::OP_SEND: begin
				if (free_cnt == 0) begin
					o.status = msq_pkg::STS_NO_FREE;
				end else if (r.message_length > slot_cap) begin
					o.status = msq_pkg::STS_TOO_BIG;
				end else begin
					free_cnt--;
					s = free_stk[free_cnt];
					slot_len[s] = r.message_length;
					slot_st[s] = msq_pkg::SS_FILLED;
					fifo_ring[(fifo_head + fifo_cnt) % SLOT_MAX] = s;
					fifo_cnt++;
					o.slot_id = msq_pkg::sid_t'(s);
					o.byte_count = r.message_length;
				end
			end
			msq_pkg::OP_GET: begin
				if (fifo_cnt == 0) begin
					o.status = msq_pkg::STS_NO_MSG;
				end else begin
					s = fifo_ring[fifo_head];
					fifo_head = (fifo_head + 1) % SLOT_MAX;
					fifo_cnt--;
					slot_st[s] = msq_pkg::SS_READ;
					o.slot_id = msq_pkg::sid_t'(s);
					o.byte_count = slot_len[s];
				end
			end
			msq_pkg::OP_PUT: begin
				if (!id_ok || slot_st[id] != msq_pkg::SS_READ) begin
					o.status = msq_pkg::STS_INVALID;
				end else begin
					slot_st[id] = msq_pkg::SS_FREE;
					free_stk[free_cnt] = id;
					free_cnt++;
				end
			end
			msq_pkg::OP_READ: begin
				if (!id_ok) begin
					o.status = msq_pkg::STS_INVALID;
				end else if (slot_st[id] != msq_pkg::SS_READ) begin
					o.status = msq_pkg::STS_NO_MSG;
				end else if (r.byte_offset >= slot_len[id]) begin
					o.status = msq_pkg::STS_INVALID;
				end else begin
					left = int'(slot_len[id]) - int'(r.byte_offset);
					o.byte_count = (r.read_capacity < left) ? r.read_capacity : 16'(left);
				end
			end
			msq_pkg::OP_RET: begin
				if (!id_ok) begin
					o.status = msq_pkg::STS_INVALID;
				end else if (slot_st[id] != msq_pkg::SS_READ) begin
					o.status = msq_pkg::STS_NO_MSG;
				end else begin
					// A returned message goes back in front of everything still queued.
					fifo_head = (fifo_head + SLOT_MAX - 1) % SLOT_MAX;
					fifo_ring[fifo_head] = id;
					fifo_cnt++;
					slot_st[id] = msq_pkg::SS_FILLED;
				end
			end
			default: begin
				o.status = msq_pkg::STS_INVALID;
			end
		endcase
		return o;
	endfunction

	// Random request, mostly aimed at slots that are held for reading so that
	// reads, puts and returns get past their first checks.
	function automatic msq_pkg::req_t pick_request();
		msq_pkg::req_t r;
		int          held [$];
		int          i;
		int          roll;
		logic [15:0] held_len;
		for (i = 0; i < pool_slots; i++)
			if (slot_st[i] == msq_pkg::SS_READ)
				held.push_back(i);
		roll = $urandom_range(0, 99);
		if (roll < 28)
			r.operation = msq_pkg::OP_SEND;
		else if (roll < 50)
			r.operation = msq_pkg::OP_GET;
		else if (roll < 70)
			r.operation = msq_pkg::OP_READ;
		else if (roll < 86)
			r.operation = msq_pkg::OP_PUT;
		else if (roll < 95)
			r.operation = msq_pkg::OP_RET;
		else
			r.operation = 3'($urandom_range(int'(msq_pkg::OP_RET) + 1, int'(OP_BAD7)));
		roll = $urandom_range(0, 99);
		if (held.size() != 0 && roll < 70)
			r.msg_id = 8'(held[$urandom_range(0, held.size() - 1)]);
		else if (pool_slots != 0 && roll < 90)
			r.msg_id = 8'($urandom_range(0, pool_slots - 1));
		else
			r.msg_id = 8'($urandom_range(0, 255));
		if (r.msg_id < pool_slots && slot_st[r.msg_id[3:0]] == msq_pkg::SS_READ)
			held_len = slot_len[r.msg_id[3:0]];
		else
			held_len = '0;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			r.message_length = 16'($urandom_range(0, slot_cap));
		else if (roll < 85)
			r.message_length = slot_cap + 16'($urandom_range(0, 1));
		else
			r.message_length = 16'($urandom_range(0, 65535));
		roll = $urandom_range(0, 99);
		if (roll < 65)
			r.byte_offset = (held_len == 0) ? 16'd0 : 16'($urandom_range(0, held_len - 1));
		else if (roll < 80)
			r.byte_offset = held_len;
		else
			r.byte_offset = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 1) == 0)
			r.read_capacity = 16'($urandom_range(0, 65535));
		else
			r.read_capacity = 16'($urandom_range(0, 64));
		return r;
	endfunction

	// Offer one request and hold it until it is taken, then book its answer.
	task automatic issue(input msq_pkg::req_t r, input logic typed, input msq_pkg::rsp_t fixed);
		msq_pkg::rsp_t want;
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		want = pool_apply(r);
		if (typed)
			want = fixed;
		pool_answers.push_back(want);
	endtask

	// Random gap after a request, skipped during the calm stretch.
	task automatic pace();
		if (!calm && $urandom_range(0, 99) < 11) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every owed answer.
	task automatic quiesce();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pool_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [msq_pkg::CFG_AW-1:0] addr,
			input logic [msq_pkg::CFG_DW-1:0] val);
		quiesce();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_SLOTS) begin
			// Counts above the pool size saturate; any count write rebuilds the pool.
			pool_slots = (val[4:0] > SLOT_MAX) ? SLOT_MAX : int'(val[4:0]);
			pool_reset();
		end else begin
			slot_cap = val[15:0];
		end
	endtask

	// Response side: checks every accepted answer and paces rsp_ready, with a
	// long hold-off on request from the stimulus side.
	always @(posedge clk) begin : rsp_side
		msq_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pool_answers.size() == 0) begin
				$display("%0t: answer with none owed: status %0d slot %0d count %0d",
					$time, rsp_data.status, rsp_data.slot_id, rsp_data.byte_count);
				err_cnt++;
			end else begin
				want = pool_answers.pop_front();
				if (rsp_data.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, rsp_data.status);
					err_cnt++;
				end
				if (rsp_data.slot_id !== want.slot_id) begin
					$display("%0t: slot_id expected %0d, got %0d",
						$time, want.slot_id, rsp_data.slot_id);
					err_cnt++;
				end
				if (rsp_data.byte_count !== want.byte_count) begin
					$display("%0t: byte_count expected %0d, got %0d",
						$time, want.byte_count, rsp_data.byte_count);
					err_cnt++;
				end
			end
		end
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (calm) begin
			rsp_ready <= 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= 11);
		end
	end

	initial begin
		#5ms;
		$display("** message_slot_queue_core: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int p;
		int k;
		pool_slots = SLOT_MAX;
		slot_cap = 16'd4096;
		pool_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < PROBES; k++) begin
			issue(probe_tab[k].r, probe_tab[k].typed, probe_tab[k].e);
			pace();
		end

		for (p = 0; p < PHASES; p++) begin
			write_reg(ADDR_BYTES, ph_bytes[p]);
			write_reg(ADDR_SLOTS, ph_slots[p]);
			for (k = 0; k < ph_items[p]; k++) begin
				calm = (p == 6 && k < 150);
				// Starve the response side so the core backs up into the request side.
				if ((p == 0 && k == 60) || (p == 7 && k == 100))
					hold_go = 1'b1;
				// Drain completely mid-stream, once with a size change on top.
				if (p == 2 && k == 120)
					quiesce();
				if (p == 6 && k == 110)
					write_reg(ADDR_BYTES, 32'd50);
				issue(pick_request(), 1'b0, '0);
				pace();
			end
		end
		calm = 1'b0;

		quiesce();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("** message_slot_queue_core: PASSED **");
		else
			$display("** message_slot_queue_core: FAILED **");
		$finish;
	end

endmodule

// ----- message_slot_queue_core.f -----
hdl/msq_pkg.sv
hdl/msq_ram.sv
hdl/message_slot_queue_core.sv
bench/message_slot_queue_core_tb.sv
